/* rtl/hjg_pkg.sv */
// ----------------------------------------------------------------------------
// hjg_pkg
// Shared types, widths, tables and saturation helpers for the hex8 Jacobian
// gradient block.
// ----------------------------------------------------------------------------
package hjg_pkg;

	localparam int COORD_BITS_DEF = 32;
	localparam int NAT_FRAC_DEF   = 14;
	localparam int NAT_W          = 16;
	localparam int SHAPE_W        = 15;
	localparam int GRAD_W         = 32;
	localparam int DET_W          = 48;
	localparam int NODE_W         = 3;
	localparam int PW             = 128;  // product / wide word width
	localparam int AW             = 64;   // jacobian sum and cofactor width
	localparam int JW             = 32;   // rounded jacobian entry width

	typedef enum logic [3:0] {
		S_IDLE,
		S_DERIV,
		S_JACC,
		S_JROUND,
		S_COF,
		S_DET,
		S_DETFIN,
		S_ODERIV,
		S_NUM,
		S_DIV,
		S_OUT
	} state_t;

	// cofactor terms: cf[m] = j[a]*j[b] - j[c]*j[d]
	typedef struct packed {
		logic [3:0] a;
		logic [3:0] b;
		logic [3:0] c;
		logic [3:0] d;
	} cof_sel_t;

	// corner sign along axis k is positive
	function automatic logic corner_pos(logic [2:0] n, logic [1:0] k);
		logic r;
		case (k)
			2'd0:    r = n[0] ^ n[1];
			2'd1:    r = n[1];
			default: r = n[2];
		endcase
		return r;
	endfunction

	// row of a 3x3 walk index
	function automatic logic [1:0] walk_row(logic [3:0] i);
		logic [1:0] r;
		case (i)
			4'd0, 4'd1, 4'd2: r = 2'd0;
			4'd3, 4'd4, 4'd5: r = 2'd1;
			default:          r = 2'd2;
		endcase
		return r;
	endfunction

	// column of a 3x3 walk index
	function automatic logic [1:0] walk_col(logic [3:0] i);
		logic [1:0] r;
		case (i)
			4'd0, 4'd3, 4'd6: r = 2'd0;
			4'd1, 4'd4, 4'd7: r = 2'd1;
			default:          r = 2'd2;
		endcase
		return r;
	endfunction

	function automatic cof_sel_t cof_sel(logic [3:0] m);
		cof_sel_t s;
		case (m)
			4'd0:    s = '{4'd4, 4'd8, 4'd5, 4'd7};
			4'd1:    s = '{4'd5, 4'd6, 4'd3, 4'd8};
			4'd2:    s = '{4'd3, 4'd7, 4'd4, 4'd6};
			4'd3:    s = '{4'd2, 4'd7, 4'd1, 4'd8};
			4'd4:    s = '{4'd0, 4'd8, 4'd2, 4'd6};
			4'd5:    s = '{4'd1, 4'd6, 4'd0, 4'd7};
			4'd6:    s = '{4'd1, 4'd5, 4'd2, 4'd4};
			4'd7:    s = '{4'd2, 4'd3, 4'd0, 4'd5};
			default: s = '{4'd0, 4'd4, 4'd1, 4'd3};
		endcase
		return s;
	endfunction

	function automatic logic signed [AW-1:0] sat64(logic signed [PW-1:0] v);
		logic signed [PW-1:0] hi;
		logic signed [PW-1:0] lo;
		hi = PW'({1'b0, {(AW-1){1'b1}}});
		lo = -hi - PW'(1);
		if (v > hi) return AW'(hi);
		if (v < lo) return AW'(lo);
		return v[AW-1:0];
	endfunction

	function automatic logic signed [DET_W-1:0] sat48(logic signed [PW-1:0] v);
		logic signed [PW-1:0] hi;
		logic signed [PW-1:0] lo;
		hi = PW'({1'b0, {(DET_W-1){1'b1}}});
		lo = -hi - PW'(1);
		if (v > hi) return DET_W'(hi);
		if (v < lo) return DET_W'(lo);
		return v[DET_W-1:0];
	endfunction

	function automatic logic signed [JW-1:0] sat32(logic signed [PW-1:0] v);
		logic signed [PW-1:0] hi;
		logic signed [PW-1:0] lo;
		hi = PW'({1'b0, {(JW-1){1'b1}}});
		lo = -hi - PW'(1);
		if (v > hi) return JW'(hi);
		if (v < lo) return JW'(lo);
		return v[JW-1:0];
	endfunction

endpackage

/* rtl/hex8_jacobian_gradients_top.sv */
// ----------------------------------------------------------------------------
// hex8_jacobian_gradients_top
// Trilinear hex8 element: Jacobian, determinant and physical shape gradients.
// ----------------------------------------------------------------------------
// An element is eight input items, one per corner node; the natural point is
// taken from the first item of each element. in_ready is high only while the
// block is idle. Each item costs 3 derivative and 9 accumulate products on one
// shared shift-add multiplier. After the eighth item the block rounds the
// Jacobian, forms 18 cofactor and 3 determinant products, then for each node
// runs 14 more products and 3 divisions on the restoring divider (one quotient
// bit a cycle) before showing that node's result item. Results come in node
// order 0..7, last on node 7; a zero rounded determinant flags singular and
// zeroes the gradients.
module hex8_jacobian_gradients_top #(
	parameter int COORD_BITS    = hjg_pkg::COORD_BITS_DEF,
	parameter int NAT_FRAC_BITS = hjg_pkg::NAT_FRAC_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [hjg_pkg::NODE_W-1:0]          node_index,
	input  logic signed [COORD_BITS-1:0]        coord_x,
	input  logic signed [COORD_BITS-1:0]        coord_y,
	input  logic signed [COORD_BITS-1:0]        coord_z,
	input  logic signed [hjg_pkg::NAT_W-1:0]    nat_xi,
	input  logic signed [hjg_pkg::NAT_W-1:0]    nat_eta,
	input  logic signed [hjg_pkg::NAT_W-1:0]    nat_zeta,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [hjg_pkg::NODE_W-1:0]          out_node,
	output logic [hjg_pkg::SHAPE_W-1:0]         shape_value,
	output logic signed [hjg_pkg::GRAD_W-1:0]   grad_x,
	output logic signed [hjg_pkg::GRAD_W-1:0]   grad_y,
	output logic signed [hjg_pkg::GRAD_W-1:0]   grad_z,
	output logic signed [hjg_pkg::DET_W-1:0]    jac_det,
	output logic                                singular,
	output logic                                last
);
	import hjg_pkg::*;

	// factor 1 +- v fits in this many signed bits
	localparam int FW = ((NAT_FRAC_BITS > NAT_W - 1) ? NAT_FRAC_BITS : NAT_W - 1) + 3;
	// rounded shape derivative width
	localparam int DW = 2 * FW - NAT_FRAC_BITS - 3 + 1;
	localparam int SD = NAT_FRAC_BITS + 3;
	localparam int SS = 2 * NAT_FRAC_BITS + 3;

	localparam logic signed [FW-1:0] ONE_F  = FW'(1) << NAT_FRAC_BITS;
	localparam logic signed [PW-1:0] RND_D  = PW'(1) << (SD - 1);
	localparam logic signed [PW-1:0] RND_S  = PW'(1) << (SS - 1);
	localparam logic signed [PW-1:0] RND_F  = PW'(1) << (NAT_FRAC_BITS - 1);
	localparam logic signed [PW-1:0] RND_32 = PW'(1) << 31;
	localparam logic signed [JW-1:0] J_MIN  = -JW'({1'b0, {(JW-1){1'b1}}});
	localparam logic signed [PW-1:0] SHAPE_MAX = PW'({SHAPE_W{1'b1}});

	// control state
	state_t       state_q, state_d;
	logic [4:0]   idx_q;
	logic         issued_q;
	logic [2:0]   cnt_q;          // nodes seen in this element
	logic [2:0]   onode_q;        // result node being worked on

	// element state
	logic signed [NAT_W-1:0]      nat_q [3];
	logic signed [AW-1:0]         jac_q [9];

	// working registers
	logic [NODE_W-1:0]            node_q;
	logic signed [COORD_BITS-1:0] c_q   [3];
	logic signed [DW-1:0]         d_q   [3];
	logic signed [JW-1:0]         j_q   [9];
	logic signed [AW-1:0]         cf_q  [9];
	logic signed [AW-1:0]         tmp_q;
	logic signed [PW-1:0]         det_q;
	logic signed [PW-1:0]         num_q [3];

	// result registers
	logic [SHAPE_W-1:0]           shape_q;
	logic signed [GRAD_W-1:0]     grad_q [3];
	logic signed [DET_W-1:0]      outdet_q;
	logic                         sing_q;

	// shared units
	logic                 mul_start, div_start;
	logic signed [AW-1:0] mul_a, mul_b;
	logic                 mul_done, div_done;
	logic signed [PW-1:0] mul_p;
	logic signed [JW-1:0] div_q;

	logic                 uses_mul, uses_div, step, at_end;
	logic [4:0]           idx_last;
	logic [NODE_W-1:0]    nsel;
	logic signed [FW-1:0] fac [3];
	logic [3:0]           idx4;
	logic [1:0]           row, col;
	logic [3:0]           cf_idx;
	cof_sel_t             csel;
	logic signed [PW-1:0] p_d, p_s, jr, dr;

	assign idx4   = idx_q[3:0];
	assign row    = walk_row(idx4);
	assign col    = walk_col(idx4);
	assign cf_idx = {col, 1'b0} + {2'b00, col} + {2'b00, row};
	assign csel   = cof_sel(idx_q[4:1]);
	assign nsel   = (state_q == S_DERIV) ? node_q : onode_q;

	// per-axis factors 1 +- v for the selected corner
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			fac[k] = corner_pos(nsel, 2'(k)) ? ONE_F + FW'(nat_q[k])
			                                 : ONE_F - FW'(nat_q[k]);
		end
	end

	assign p_d = (mul_p + RND_D) >>> SD;
	assign p_s = (mul_p + RND_S) >>> SS;
	assign jr  = (PW'(jac_q[idx4]) + RND_F) >>> NAT_FRAC_BITS;
	assign dr  = (det_q + RND_32) >>> 32;

	// step bookkeeping
	always_comb begin
		case (state_q)
			S_DERIV:  idx_last = 5'd2;
			S_JACC:   idx_last = 5'd8;
			S_JROUND: idx_last = 5'd8;
			S_COF:    idx_last = 5'd17;
			S_DET:    idx_last = 5'd2;
			S_ODERIV: idx_last = 5'd4;
			S_NUM:    idx_last = 5'd8;
			S_DIV:    idx_last = 5'd2;
			default:  idx_last = 5'd0;
		endcase
	end

	assign uses_mul = (state_q == S_DERIV) || (state_q == S_JACC) || (state_q == S_COF) ||
	                  (state_q == S_DET) || (state_q == S_ODERIV) || (state_q == S_NUM);
	assign uses_div = (state_q == S_DIV);
	assign step     = uses_mul ? mul_done : (uses_div ? div_done : (state_q == S_JROUND));
	assign at_end   = step && (idx_q == idx_last);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:   if (in_valid) state_d = S_DERIV;
			S_DERIV:  if (at_end) state_d = S_JACC;
			S_JACC:   if (at_end) state_d = (cnt_q == 3'd7) ? S_JROUND : S_IDLE;
			S_JROUND: if (at_end) state_d = S_COF;
			S_COF:    if (at_end) state_d = S_DET;
			S_DET:    if (at_end) state_d = S_DETFIN;
			S_DETFIN: state_d = S_ODERIV;
			S_ODERIV: if (at_end) state_d = S_NUM;
			S_NUM:    if (at_end) state_d = S_DIV;
			S_DIV:    if (at_end) state_d = S_OUT;
			S_OUT:    if (out_ready) state_d = (onode_q == 3'd7) ? S_IDLE : S_ODERIV;
			default:  state_d = S_IDLE;
		endcase
	end

	// outputs and multiplier operand selection
	always_comb begin
		in_ready  = (state_q == S_IDLE);
		out_valid = (state_q == S_OUT);
		mul_start = uses_mul && !issued_q;
		div_start = uses_div && !issued_q;
		mul_a     = '0;
		mul_b     = '0;
		case (state_q)
			S_DERIV, S_ODERIV: begin
				case (idx_q)
					5'd0: begin
						mul_a = corner_pos(nsel, 2'd0) ? AW'(fac[1]) : -AW'(fac[1]);
						mul_b = AW'(fac[2]);
					end
					5'd1: begin
						mul_a = corner_pos(nsel, 2'd1) ? AW'(fac[0]) : -AW'(fac[0]);
						mul_b = AW'(fac[2]);
					end
					5'd2: begin
						mul_a = corner_pos(nsel, 2'd2) ? AW'(fac[0]) : -AW'(fac[0]);
						mul_b = AW'(fac[1]);
					end
					5'd3: begin
						// shape product, first pair
						mul_a = AW'(fac[0]);
						mul_b = AW'(fac[1]);
					end
					default: begin
						mul_a = tmp_q;
						mul_b = AW'(fac[2]);
					end
				endcase
			end
			S_JACC: begin
				mul_a = AW'(c_q[row]);
				mul_b = AW'(d_q[col]);
			end
			S_COF: begin
				mul_a = AW'(j_q[idx_q[0] ? csel.c : csel.a]);
				mul_b = AW'(j_q[idx_q[0] ? csel.d : csel.b]);
			end
			S_DET: begin
				mul_a = AW'(j_q[idx4]);
				mul_b = cf_q[idx4];
			end
			S_NUM: begin
				mul_a = cf_q[cf_idx];
				mul_b = AW'(d_q[col]);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			idx_q    <= '0;
			issued_q <= 1'b0;
			cnt_q    <= '0;
			onode_q  <= '0;
			for (int k = 0; k < 3; k++) nat_q[k] <= '0;
			for (int k = 0; k < 9; k++) jac_q[k] <= '0;
		end else begin
			state_q <= state_d;
			if (at_end) idx_q <= '0;
			else if (step) idx_q <= idx_q + 5'd1;
			if (step) issued_q <= 1'b0;
			else if (mul_start || div_start) issued_q <= 1'b1;

			if (state_q == S_IDLE && in_valid && cnt_q == 3'd0) begin
				nat_q[0] <= nat_xi;
				nat_q[1] <= nat_eta;
				nat_q[2] <= nat_zeta;
			end
			// count wraps to zero after the eighth item
			if (state_q == S_JACC && at_end) cnt_q <= cnt_q + 3'd1;
			if (state_q == S_JACC && step)
				jac_q[idx4] <= sat64(PW'(jac_q[idx4]) + mul_p);
			if (state_q == S_JROUND) jac_q[idx4] <= '0;
			if (state_q == S_DETFIN) onode_q <= '0;
			if (state_q == S_OUT && out_ready) onode_q <= onode_q + 3'd1;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					node_q <= node_index;
					c_q[0] <= coord_x;
					c_q[1] <= coord_y;
					c_q[2] <= coord_z;
				end
			end
			S_DERIV, S_ODERIV: begin
				if (step) begin
					if (idx_q == 5'd3) begin
						tmp_q <= mul_p[AW-1:0];
					end else if (idx_q == 5'd4) begin
						if (p_s < 0) shape_q <= '0;
						else if (p_s > SHAPE_MAX) shape_q <= '1;
						else shape_q <= p_s[SHAPE_W-1:0];
					end else begin
						d_q[idx_q[1:0]] <= p_d[DW-1:0];
					end
				end
				if (state_q == S_ODERIV && at_end) begin
					for (int k = 0; k < 3; k++) num_q[k] <= '0;
				end
			end
			S_JROUND: begin
				// clamp to symmetric range
				if (sat32(jr) < J_MIN) j_q[idx4] <= J_MIN;
				else j_q[idx4] <= sat32(jr);
				if (at_end) det_q <= '0;
			end
			S_COF: begin
				if (step) begin
					if (!idx_q[0]) tmp_q <= mul_p[AW-1:0];
					else cf_q[idx_q[4:1]] <= tmp_q - mul_p[AW-1:0];
				end
			end
			S_DET: begin
				if (step) det_q <= det_q + mul_p;
			end
			S_DETFIN: begin
				outdet_q <= sat48(dr);
				sing_q   <= (sat48(dr) == '0);
			end
			S_NUM: begin
				if (step) num_q[row] <= num_q[row] + mul_p;
			end
			S_DIV: begin
				if (step) grad_q[idx_q[1:0]] <= sing_q ? '0 : div_q;
			end
			default: begin
			end
		endcase
	end

	hjg_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.done   (mul_done),
		.p      (mul_p)
	);

	hjg_div #(
		.SH (32 - NAT_FRAC_BITS)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (num_q[idx_q[1:0]]),
		.den    (det_q),
		.done   (div_done),
		.quo    (div_q)
	);

	// result item
	assign out_node    = onode_q;
	assign shape_value = shape_q;
	assign grad_x      = grad_q[0];
	assign grad_y      = grad_q[1];
	assign grad_z      = grad_q[2];
	assign jac_det     = outdet_q;
	assign singular    = sing_q;
	assign last        = (onode_q == 3'd7);

	// no input item taken while a result item is shown
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input and output active together");

	// last result of an element returns the block to idle
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && last |=> in_ready)
		else $error("block not idle after last result item");

	// singular results carry zero gradients
	a_sing: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && singular |-> (grad_x == '0 && grad_y == '0 && grad_z == '0))
		else $error("nonzero gradient on singular element");

	// the shared multiplier is never restarted while a product is pending
	a_issue: assert property (@(posedge clk) disable iff (!arst_n)
		mul_start |=> !mul_start)
		else $error("multiplier restarted early");

endmodule

/* rtl/hjg_mul.sv */
// ----------------------------------------------------------------------------
// hjg_mul
// Shared shift-add multiplier, signed 64 x 64 to 128, one adder step a cycle.
// ----------------------------------------------------------------------------
module hjg_mul (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic signed [hjg_pkg::AW-1:0] a,
	input  logic signed [hjg_pkg::AW-1:0] b,
	output logic                         done,
	output logic signed [hjg_pkg::PW-1:0] p
);
	import hjg_pkg::*;

	logic          busy_q;
	logic          done_q;
	logic          neg_q;
	logic [PW-1:0] acc_q;
	logic [PW-1:0] am_q;
	logic [AW-1:0] bm_q;
	logic [PW-1:0] p_q;
	logic [AW-1:0] a_mag;
	logic [AW-1:0] b_mag;

	assign a_mag = a[AW-1] ? AW'(-a) : AW'(a);
	assign b_mag = b[AW-1] ? AW'(-b) : AW'(b);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q && bm_q == '0) begin
			busy_q <= 1'b0;
			done_q <= 1'b1;
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
			am_q  <= PW'(a_mag);
			bm_q  <= b_mag;
			neg_q <= a[AW-1] ^ b[AW-1];
		end else if (busy_q) begin
			if (bm_q == '0) begin
				p_q <= neg_q ? PW'(-acc_q) : acc_q;
			end else begin
				if (bm_q[0]) acc_q <= acc_q + am_q;
				am_q <= {am_q[PW-2:0], 1'b0};
				bm_q <= {1'b0, bm_q[AW-1:1]};
			end
		end
	end

	assign done = done_q;
	assign p    = p_q;

endmodule

/* rtl/hjg_div.sv */
// ----------------------------------------------------------------------------
// hjg_div
// Restoring divider: (num << SH) / den, rounded half away from zero,
// saturated to 32 bits; one quotient bit a cycle.
// ----------------------------------------------------------------------------
module hjg_div #(
	parameter int SH = 32 - hjg_pkg::NAT_FRAC_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic signed [hjg_pkg::PW-1:0]   num,
	input  logic signed [hjg_pkg::PW-1:0]   den,
	output logic                           done,
	output logic signed [hjg_pkg::JW-1:0]   quo
);
	import hjg_pkg::*;

	localparam int CW = $clog2(PW);

	logic          busy_q;
	logic          fin_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic          neg_q;
	logic [PW-1:0] nq_q;
	logic [PW-1:0] r_q;
	logic [PW-1:0] q_q;
	logic [PW-1:0] d_q;
	logic signed [JW-1:0] quo_q;
	logic [PW-1:0] n_mag;
	logic [PW-1:0] d_mag;
	logic [PW:0]   rs;
	logic          ge;
	logic [PW-1:0] q_rnd;
	logic signed [PW-1:0] q_sgn;

	assign n_mag = num[PW-1] ? PW'(-num) : PW'(num);
	assign d_mag = den[PW-1] ? PW'(-den) : PW'(den);
	assign rs    = {r_q, nq_q[PW-1]};
	assign ge    = rs >= {1'b0, d_q};
	assign q_rnd = (r_q >= d_q - r_q) ? q_q + PW'(1) : q_q;
	assign q_sgn = neg_q ? PW'(-q_rnd) : PW'(q_rnd);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				fin_q  <= 1'b0;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CW'(1);
				if (cnt_q == CW'(PW - 1)) begin
					busy_q <= 1'b0;
					fin_q  <= 1'b1;
				end
			end else if (fin_q) begin
				fin_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			nq_q  <= n_mag << SH;
			d_q   <= d_mag;
			r_q   <= '0;
			q_q   <= '0;
			neg_q <= num[PW-1] ^ den[PW-1];
		end else if (busy_q) begin
			r_q  <= ge ? PW'(rs - {1'b0, d_q}) : rs[PW-1:0];
			q_q  <= {q_q[PW-2:0], ge};
			nq_q <= {nq_q[PW-2:0], 1'b0};
		end else if (fin_q) begin
			quo_q <= sat32(q_sgn);
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule
